FILE: rtl/uart_rb_pkg.sv
// Shared types, register codes and helper functions for the 16550 register block.
// Depends on nothing; every other file of the block imports it.
package uart_rb_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  // Receive-timeout length: 4 * floor(10 * d * 1e6 / 115200) = 4 * floor(d * 3125 / 36).
  // floor(d * 3125 / 36) == (d * TMO_MULT) >> TMO_SHIFT for every 16-bit d.
  localparam int TMO_SHIFT = 22;
  localparam int TMO_MULT_W = 29;
  localparam logic [TMO_MULT_W-1:0] TMO_MULT = 29'd364088889;
  localparam int DIV_W = 16;
  localparam int TMO_W = 25;

  // Output word queue.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW = 2;
  localparam int OUTQ_CW = 3;

  // Operation codes.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Register offsets.
  localparam logic [2:0] REG_THR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  // Interrupt identification codes (low nibble of IIR).
  localparam logic [3:0] IIR_LINE = 4'h6;
  localparam logic [3:0] IIR_RXD  = 4'h4;
  localparam logic [3:0] IIR_TMO  = 4'hc;
  localparam logic [3:0] IIR_THRE = 4'h2;
  localparam logic [3:0] IIR_MDM  = 4'h0;
  localparam logic [3:0] IIR_NONE = 4'h1;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] register_offset;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } out_word_t;

  // Result leaving the register stage; read data may still come from the FIFO memory.
  typedef struct packed {
    logic      use_mem;
    out_word_t word;
  } stage_word_t;

  function automatic logic [3:0] trig_level(input logic [1:0] sel);
    logic [3:0] lvl;
    case (sel)
      2'd0:    lvl = 4'd1;
      2'd1:    lvl = 4'd4;
      2'd2:    lvl = 4'd8;
      default: lvl = 4'd14;
    endcase
    return lvl;
  endfunction

  function automatic logic [7:0] iir_value(input logic [3:0] ier, input logic [3:0] err,
                                           input logic dr, input logic fifo_en,
                                           input logic at_trig, input logic tmo_pend,
                                           input logic thr_pend, input logic [3:0] msr_delta);
    logic [3:0] id;
    if (ier[2] && (err != 4'd0))
      id = IIR_LINE;
    else if (ier[0] && dr && (!fifo_en || at_trig))
      id = IIR_RXD;
    else if (ier[0] && tmo_pend)
      id = IIR_TMO;
    else if (ier[1] && thr_pend)
      id = IIR_THRE;
    else if (ier[3] && (msr_delta != 4'd0))
      id = IIR_MDM;
    else
      id = IIR_NONE;
    return {(fifo_en ? 2'b11 : 2'b00), 2'b00, id};
  endfunction

  // MSR after an MCR write: loopback routes MCR outputs to the modem inputs,
  // changes set the sticky delta bits.
  function automatic logic [7:0] msr_update(input logic [7:0] mcr, input logic [7:0] msr);
    logic [3:0] lines;
    logic [3:0] diff;
    lines = mcr[4] ? {mcr[3], mcr[2], mcr[0], mcr[1]} : 4'd0;
    diff = lines ^ msr[7:4];
    return {lines, diff | msr[3:0]};
  endfunction

endpackage

FILE: rtl/uart_rb_mem.sv
// Receive FIFO storage: one write port, one read port, registered read data.
// Depends on uart_rb_pkg.
module uart_rb_mem import uart_rb_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [PTR_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] store_r [FIFO_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) store_r[waddr] <= wdata;
    if (re) rdata_r <= store_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/uart_rb_tmo.sv
// Character-timeout length from the divisor captured at the last received byte.
// Depends on uart_rb_pkg. One multiply, registered.
module uart_rb_tmo import uart_rb_pkg::*; (
  input  logic             clk,
  input  logic [DIV_W-1:0] divisor,
  output logic [TMO_W-1:0] tmo_len
);

  localparam int PROD_W = DIV_W + TMO_MULT_W;

  logic [DIV_W-1:0]  div_eff;
  logic [PROD_W-1:0] prod;
  logic [TMO_W-1:0]  len_r;
  logic [TMO_W-1:0]  len_nxt;

  // zero divisor behaves as one
  assign div_eff = (divisor == '0) ? DIV_W'(1) : divisor;
  assign prod    = PROD_W'(div_eff) * PROD_W'(TMO_MULT);
  assign len_nxt = {prod[TMO_SHIFT +: TMO_W-2], 2'b00};

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  assign tmo_len = len_r;

endmodule

FILE: rtl/uart_rb_regs.sv
// Register file and FIFO pointer control: one read-modify-write per accepted word.
// Depends on uart_rb_pkg; drives uart_rb_mem ports and feeds uart_rb_outq.
module uart_rb_regs import uart_rb_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(FIFO_DEPTH),
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_word_t         in_data,
  output logic             mem_we,
  output logic [PTR_W-1:0] mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic             mem_re,
  output logic [PTR_W-1:0] mem_raddr,
  output logic [DIV_W-1:0] tmo_div,
  input  logic [TMO_W-1:0] tmo_len,
  output logic             st_valid,
  output stage_word_t      st_data
);

  logic [DIV_W-1:0] div_r, div_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       fcr_r, fcr_nxt;
  logic [7:0]       lcr_r, lcr_nxt;
  logic [7:0]       mcr_r, mcr_nxt;
  logic [3:0]       err_r, err_nxt;   // LSR bits 4:1
  logic [7:0]       msr_r, msr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [3:0]       trig_r, trig_nxt;
  logic             thr_pend_r, thr_pend_nxt;
  logic             tmo_pend_r, tmo_pend_nxt;
  logic             tmo_arm_r, tmo_arm_nxt;
  logic [TMO_W-1:0] tmo_cnt_r, tmo_cnt_nxt; // ticks since the last reload
  logic [DIV_W-1:0] dcap_r, dcap_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic             st_valid_r;
  stage_word_t      st_data_r, st_data_nxt;

  logic             accept;
  logic             dlab;
  logic             loopback;
  logic             push;
  logic             we_raw;
  logic             re_raw;
  logic             sent;
  logic [7:0]       rd;
  logic             use_mem;
  logic [7:0]       iir_cur;
  logic [7:0]       iir_nxt;
  logic [7:0]       lsr_cur;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign dlab     = lcr_r[7];
  assign loopback = mcr_r[4];
  assign lsr_cur  = {1'b0, 2'b11, err_r, (fill_r != '0)};
  assign iir_cur  = iir_value(ier_r, err_r, (fill_r != '0), fcr_r[0],
                              (fill_r >= CNT_W'(trig_r)), tmo_pend_r, thr_pend_r, msr_r[3:0]);

  always_comb begin
    div_nxt      = div_r;
    ier_nxt      = ier_r;
    fcr_nxt      = fcr_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    err_nxt      = err_r;
    msr_nxt      = msr_r;
    scr_nxt      = scr_r;
    trig_nxt     = trig_r;
    thr_pend_nxt = thr_pend_r;
    tmo_pend_nxt = tmo_pend_r;
    tmo_arm_nxt  = tmo_arm_r;
    tmo_cnt_nxt  = tmo_cnt_r;
    dcap_nxt     = dcap_r;
    wptr_nxt     = wptr_r;
    rptr_nxt     = rptr_r;
    fill_nxt     = fill_r;
    push         = 1'b0;
    we_raw       = 1'b0;
    re_raw       = 1'b0;
    sent         = 1'b0;
    rd           = 8'h00;
    use_mem      = 1'b0;

    case (in_data.operation)
      OP_READ: begin
        case (in_data.register_offset)
          REG_THR: begin
            if (dlab) begin
              rd = div_r[7:0];
            end else begin
              if (fill_r != '0) begin
                re_raw   = 1'b1;
                use_mem  = 1'b1;
                rptr_nxt = ptr_inc(rptr_r);
                fill_nxt = fill_r - CNT_W'(1);
              end
              tmo_pend_nxt = 1'b0;
              tmo_arm_nxt  = 1'b0;
            end
          end
          REG_IER: rd = dlab ? div_r[15:8] : {4'd0, ier_r};
          REG_IIR: begin
            rd           = iir_cur;
            thr_pend_nxt = 1'b0;
          end
          REG_LCR: rd = lcr_r;
          REG_MCR: rd = mcr_r;
          REG_LSR: begin
            rd      = lsr_cur;
            err_nxt = 4'd0;
          end
          REG_MSR: begin
            rd      = msr_r;
            msr_nxt = {msr_r[7:4], 4'd0};
          end
          default: rd = scr_r;
        endcase
      end
      OP_WRITE: begin
        case (in_data.register_offset)
          REG_THR: begin
            if (dlab)
              div_nxt = {div_r[15:8], in_data.data_byte};
            else if (loopback)
              push = 1'b1;
            else
              sent = 1'b1;
            thr_pend_nxt = 1'b1;
          end
          REG_IER: begin
            if (dlab)
              div_nxt = {in_data.data_byte, div_r[7:0]};
            else
              ier_nxt = in_data.data_byte[3:0];
          end
          REG_IIR: begin
            fcr_nxt = in_data.data_byte;
            if (in_data.data_byte[1]) begin
              fill_nxt     = '0;
              wptr_nxt     = '0;
              rptr_nxt     = '0;
              tmo_arm_nxt  = 1'b0;
              tmo_pend_nxt = 1'b0;
              err_nxt      = 4'd0;
            end
            trig_nxt = trig_level(in_data.data_byte[7:6]);
          end
          REG_LCR: begin
            lcr_nxt    = in_data.data_byte;
            err_nxt[3] = in_data.data_byte[6];  // break control mirrors into LSR.BI
          end
          REG_MCR: begin
            mcr_nxt = in_data.data_byte;
            msr_nxt = msr_update(in_data.data_byte, msr_r);
          end
          REG_SCR: scr_nxt = in_data.data_byte;
          default: ;  // LSR and MSR are read-only
        endcase
      end
      OP_RX: begin
        if (!loopback) push = 1'b1;
      end
      default: begin
        if (tmo_arm_r) begin
          if ((tmo_cnt_r + TMO_W'(1)) >= tmo_len) begin
            tmo_arm_nxt = 1'b0;
            tmo_cnt_nxt = '0;
            if (fill_r != '0) tmo_pend_nxt = 1'b1;
          end else begin
            tmo_cnt_nxt = tmo_cnt_r + TMO_W'(1);
          end
        end
      end
    endcase

    if (push) begin
      if (fill_r == CNT_W'(FIFO_DEPTH)) begin
        err_nxt[0] = 1'b1;  // overrun, byte dropped
      end else begin
        we_raw   = 1'b1;
        wptr_nxt = ptr_inc(wptr_r);
        fill_nxt = fill_r + CNT_W'(1);
      end
      if (fcr_r[0]) begin
        tmo_arm_nxt = 1'b1;
        tmo_cnt_nxt = '0;
        dcap_nxt    = div_r;
      end
    end

    iir_nxt = iir_value(ier_nxt, err_nxt, (fill_nxt != '0), fcr_nxt[0],
                        (fill_nxt >= CNT_W'(trig_nxt)), tmo_pend_nxt, thr_pend_nxt,
                        msr_nxt[3:0]);

    st_data_nxt.use_mem        = use_mem;
    st_data_nxt.word.read_data = rd;
    st_data_nxt.word.irq_line  = !iir_nxt[0];
    st_data_nxt.word.tx_valid  = sent;
    st_data_nxt.word.tx_byte   = sent ? in_data.data_byte : 8'h00;
  end

  assign mem_we    = accept && we_raw;
  assign mem_waddr = wptr_r;
  assign mem_wdata = in_data.data_byte;
  assign mem_re    = accept && re_raw;
  assign mem_raddr = rptr_r;
  assign tmo_div   = dcap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r      <= '0;
      ier_r      <= '0;
      fcr_r      <= '0;
      lcr_r      <= '0;
      mcr_r      <= '0;
      err_r      <= '0;
      msr_r      <= '0;
      scr_r      <= '0;
      trig_r     <= 4'd1;
      thr_pend_r <= 1'b1;
      tmo_pend_r <= 1'b0;
      tmo_arm_r  <= 1'b0;
      tmo_cnt_r  <= '0;
      dcap_r     <= '0;
      wptr_r     <= '0;
      rptr_r     <= '0;
      fill_r     <= '0;
    end else if (accept) begin
      div_r      <= div_nxt;
      ier_r      <= ier_nxt;
      fcr_r      <= fcr_nxt;
      lcr_r      <= lcr_nxt;
      mcr_r      <= mcr_nxt;
      err_r      <= err_nxt;
      msr_r      <= msr_nxt;
      scr_r      <= scr_nxt;
      trig_r     <= trig_nxt;
      thr_pend_r <= thr_pend_nxt;
      tmo_pend_r <= tmo_pend_nxt;
      tmo_arm_r  <= tmo_arm_nxt;
      tmo_cnt_r  <= tmo_cnt_nxt;
      dcap_r     <= dcap_nxt;
      wptr_r     <= wptr_nxt;
      rptr_r     <= rptr_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) st_data_r <= st_data_nxt;
  end

  assign st_valid = st_valid_r;
  assign st_data  = st_data_r;

endmodule

FILE: rtl/uart_rb_outq.sv
// Output word queue: merges FIFO read data into the result and decouples the
// output stall from the input side. Depends on uart_rb_pkg.
module uart_rb_outq import uart_rb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        st_valid,
  input  stage_word_t st_data,
  input  logic [7:0]  mem_rdata,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);

  out_word_t          q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wp_r, wp_nxt;
  logic [OUTQ_AW-1:0] rp_r, rp_nxt;
  logic [OUTQ_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;
  out_word_t          entry;

  always_comb begin
    entry = st_data.word;
    if (st_data.use_mem) entry.read_data = mem_rdata;
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;

  // Room must exist for the word in the register stage plus a new one.
  assign in_stall = (cnt_r == OUTQ_CW'(OUTQ_DEPTH)) ||
                    ((cnt_r == OUTQ_CW'(OUTQ_DEPTH - 1)) && st_valid);

  always_comb begin
    wp_nxt  = st_valid ? wp_r + OUTQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + OUTQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OUTQ_CW'(st_valid) - OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid) q_r[wp_r] <= entry;
  end

endmodule

FILE: rtl/uart_16550_register_block_core.sv
// 16550 UART register file with receive FIFO, loopback and prioritized IIR.
// Depends on uart_rb_pkg, uart_rb_regs, uart_rb_mem, uart_rb_tmo, uart_rb_outq.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one word per bus read,
//   bus write, received line byte or microsecond tick. Output channel
//   (out_valid / out_stall / out_data) returns exactly one word per input word,
//   in order: read data, interrupt level after the word, and the transmit byte.
//   An accepted word passes the register stage and then the output queue.
//   Throughput: one word per cycle while in_stall is low; every word does a
//   single register update and at most one receive-FIFO memory access (write
//   at the tail, read at the head). The FIFO read data is registered in the
//   memory and is merged on the way into a four-word output queue.
//   When the receiver holds out_stall, results collect in the output queue;
//   in_stall rises once the queue and the register stage together cannot take
//   another word, and falls as soon as one word leaves.
//   Reset (rst_n low, synchronous) restores the power-up register values, empties
//   the FIFO and the output queue; no clearing pass is needed.
module uart_16550_register_block_core import uart_rb_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic [DIV_W-1:0] tmo_div;
  logic [TMO_W-1:0] tmo_len;
  logic             st_valid;
  stage_word_t      st_data;

  uart_rb_regs #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .tmo_div   (tmo_div),
    .tmo_len   (tmo_len),
    .st_valid  (st_valid),
    .st_data   (st_data)
  );

  uart_rb_mem #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  uart_rb_tmo u_tmo (
    .clk     (clk),
    .divisor (tmo_div),
    .tmo_len (tmo_len)
  );

  uart_rb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_data   (st_data),
    .mem_rdata (mem_rdata),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sim/uart_rb_checker.sv
// Response predictor and comparator for uart_16550_register_block_core.
// Watches the in_/out_ handshakes and counts mismatches; needs uart_rb_pkg.
module uart_rb_checker import uart_rb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        n_fail,
  output int        n_pending
);

  localparam int RX_DEPTH = FIFO_DEPTH_DEF;
  localparam longint unsigned BAUD_BASE = 115200;
  localparam longint unsigned US_PER_S = 1000000;
  localparam logic [7:0] LSR_DR = 8'h01;
  localparam logic [7:0] LSR_OE = 8'h02;
  localparam logic [7:0] LSR_BI = 8'h10;
  localparam logic [7:0] LSR_ERR = 8'h1e;
  localparam logic [7:0] LSR_TXE = 8'h60;
  localparam logic [7:0] IIR_RESET = 8'h01;

  logic [7:0]  rx_mem [RX_DEPTH];
  logic [3:0]  rx_head;
  logic [3:0]  rx_tail;
  logic [4:0]  rx_used;
  logic [15:0] divisor;
  logic [3:0]  ier;
  logic [7:0]  iir;
  logic [7:0]  fcr;
  logic [7:0]  lcr;
  logic [7:0]  mcr;
  logic [7:0]  lsr;
  logic [7:0]  msr;
  logic [7:0]  scr;
  logic [4:0]  rx_thresh;
  logic        thre_pend;
  logic        tmo_pend;
  logic        tmo_armed;
  logic [24:0] tmo_left;

  out_word_t response_q[$];
  out_word_t want;

  function automatic void sync_lsr();
    lsr = (lsr & LSR_ERR) | LSR_TXE | ((rx_used != 5'd0) ? LSR_DR : 8'h00);
  endfunction

  function automatic void sync_iir();
    logic [3:0] id;
    if (ier[2] && ((lsr & LSR_ERR) != 8'h00))
      id = IIR_LINE;
    else if (ier[0] && lsr[0] && (!fcr[0] || rx_used >= rx_thresh))
      id = IIR_RXD;
    else if (ier[0] && tmo_pend)
      id = IIR_TMO;
    else if (ier[1] && thre_pend)
      id = IIR_THRE;
    else if (ier[3] && (msr[3:0] != 4'h0))
      id = IIR_MDM;
    else
      id = IIR_NONE;
    iir = {fcr[0], fcr[0], 2'b00, id};
  endfunction

  function automatic void rx_push(input logic [7:0] b);
    longint unsigned d;
    if (rx_used == 5'(RX_DEPTH)) begin
      lsr = lsr | LSR_OE;
    end else begin
      rx_mem[rx_tail] = b;
      rx_tail = rx_tail + 4'd1;
      rx_used = rx_used + 5'd1;
    end
    sync_lsr();
    if (fcr[0]) begin
      // four 10-bit character times, counted in microsecond ticks
      d = (divisor == 16'd0) ? 64'd1 : 64'(divisor);
      tmo_armed = 1'b1;
      tmo_left = 25'(4 * ((10 * d * US_PER_S) / BAUD_BASE));
    end
  endfunction

  function automatic void reset_regs();
    rx_head = '0;
    rx_tail = '0;
    rx_used = '0;
    divisor = '0;
    ier = '0;
    fcr = '0;
    lcr = '0;
    mcr = '0;
    lsr = '0;
    msr = '0;
    scr = '0;
    rx_thresh = 5'd1;
    thre_pend = 1'b1;
    tmo_pend = 1'b0;
    tmo_armed = 1'b0;
    tmo_left = '0;
    iir = IIR_RESET;
    sync_lsr();
    sync_iir();
  endfunction

  function automatic out_word_t predict_response(input in_word_t w);
    out_word_t  r;
    logic       sent;
    logic [3:0] lines;
    logic [7:0] v;
    r = '0;
    sent = 1'b0;
    case (w.operation)
      OP_READ: begin
        case (w.register_offset)
          REG_THR: begin
            if (lcr[7]) begin
              v = divisor[7:0];
            end else begin
              v = 8'h00;
              if (rx_used != 5'd0) begin
                v = rx_mem[rx_head];
                rx_head = rx_head + 4'd1;
                rx_used = rx_used - 5'd1;
              end
              tmo_pend = 1'b0;
              tmo_armed = 1'b0;
              sync_lsr();
            end
          end
          REG_IER: v = lcr[7] ? divisor[15:8] : {4'h0, ier};
          REG_IIR: begin
            v = iir;
            thre_pend = 1'b0;
          end
          REG_LCR: v = lcr;
          REG_MCR: v = mcr;
          REG_LSR: begin
            v = lsr;
            lsr = lsr & ~LSR_ERR;
          end
          REG_MSR: begin
            v = msr;
            msr = {msr[7:4], 4'h0};
          end
          default: v = scr;
        endcase
        r.read_data = v;
      end
      OP_WRITE: begin
        v = w.data_byte;
        case (w.register_offset)
          REG_THR: begin
            if (lcr[7])
              divisor[7:0] = v;
            else if (mcr[4])
              rx_push(v);
            else
              sent = 1'b1;
            thre_pend = 1'b1;
          end
          REG_IER: begin
            if (lcr[7])
              divisor[15:8] = v;
            else
              ier = v[3:0];
          end
          REG_IIR: begin
            fcr = v;
            if (v[1]) begin
              rx_head = '0;
              rx_tail = '0;
              rx_used = '0;
              tmo_armed = 1'b0;
              tmo_pend = 1'b0;
              lsr = lsr & ~LSR_ERR;
            end
            case (v[7:6])
              2'd0:    rx_thresh = 5'd1;
              2'd1:    rx_thresh = 5'd4;
              2'd2:    rx_thresh = 5'd8;
              default: rx_thresh = 5'd14;
            endcase
            sync_lsr();
          end
          REG_LCR: begin
            lcr = v;
            lsr = v[6] ? (lsr | LSR_BI) : (lsr & ~LSR_BI);
            sync_lsr();
          end
          REG_MCR: begin
            mcr = v;
            // loopback: DTR->DSR, RTS->CTS, OUT1->RI, OUT2->DCD
            lines[0] = v[4] & v[1];
            lines[1] = v[4] & v[0];
            lines[2] = v[4] & v[2];
            lines[3] = v[4] & v[3];
            msr = {lines, msr[3:0] | (lines ^ msr[7:4])};
          end
          REG_LSR, REG_MSR: ;
          default: scr = v;
        endcase
      end
      OP_RX: begin
        if (!mcr[4]) rx_push(w.data_byte);
      end
      default: begin
        if (tmo_armed) begin
          if (tmo_left > 25'd1) begin
            tmo_left = tmo_left - 25'd1;
          end else begin
            tmo_left = '0;
            tmo_armed = 1'b0;
            if (rx_used != 5'd0) tmo_pend = 1'b1;
          end
        end
      end
    endcase
    sync_iir();
    r.irq_line = ~iir[0];
    r.tx_valid = sent;
    r.tx_byte = sent ? w.data_byte : 8'h00;
    return r;
  endfunction

  task automatic report(input string what, input logic [17:0] exp_v, input logic [17:0] got_v);
    n_fail++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_regs();
      response_q.delete();
    end else begin
      // a result never leaves in the cycle in which its word is accepted, so pop before push
      if (out_valid && !out_stall) begin
        if (response_q.size() == 0) begin
          report("unrequested word", 18'd0, out_data);
        end else begin
          want = response_q.pop_front();
          if (out_data.read_data !== want.read_data)
            report("read_data", 18'(want.read_data), 18'(out_data.read_data));
          if (out_data.irq_line !== want.irq_line)
            report("irq_line", 18'(want.irq_line), 18'(out_data.irq_line));
          if (out_data.tx_valid !== want.tx_valid)
            report("tx_valid", 18'(want.tx_valid), 18'(out_data.tx_valid));
          if (out_data.tx_byte !== want.tx_byte)
            report("tx_byte", 18'(want.tx_byte), 18'(out_data.tx_byte));
        end
      end
      if (in_valid && !in_stall) response_q.push_back(predict_response(in_data));
    end
    n_pending = response_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// Top of the uart_16550_register_block_core testbench: clock, reset, stimulus, verdict.
// Depends on uart_rb_pkg, the block's RTL and uart_rb_checker.
module tb_top;
  import uart_rb_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int TMO_TICKS = 340;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        n_fail;
  int        n_pending;
  int        n_sent = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        cycles = 0;

  uart_16550_register_block_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  uart_rb_checker u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .n_fail   (n_fail),
    .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL uart_16550_register_block_core");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte(input int unsigned hi);
    return 8'($urandom_range(hi));
  endfunction

  function automatic logic [2:0] rand_off();
    return 3'($urandom_range(7));
  endfunction

  // Register write data, biased so that most of the run keeps RBR visible,
  // the line free of break and loopback off, with the FIFO mostly enabled.
  function automatic logic [7:0] write_value(input logic [2:0] off);
    logic [7:0] v;
    v = rand_byte(255);
    case (off)
      REG_LCR: begin
        if ($urandom_range(3) != 0) v[7] = 1'b0;
        if ($urandom_range(3) != 0) v[6] = 1'b0;
      end
      REG_MCR: begin
        if ($urandom_range(2) != 0) v[4] = 1'b0;
      end
      REG_IIR: begin
        if ($urandom_range(3) != 0) v[0] = 1'b1;
        if ($urandom_range(2) != 0) v[1] = 1'b0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [2:0] off, input logic [7:0] val);
    in_word_t w;
    int       ph;
    ph = (n_sent / PHASE_ITEMS) % 4;
    case (ph)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
      default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
    endcase
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    w.operation = op;
    w.register_offset = off;
    w.data_byte = val;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_random_item();
    logic [1:0] op;
    logic [2:0] off;
    int         pick;
    pick = $urandom_range(99);
    off = rand_off();
    if (pick < 35) begin
      op = OP_READ;
      if ($urandom_range(99) < 40) off = REG_THR;
    end else if (pick < 55) begin
      op = OP_WRITE;
    end else if (pick < 85) begin
      op = OP_RX;
    end else begin
      op = OP_TICK;
    end
    send_word(op, off, (op == OP_WRITE) ? write_value(off) : rand_byte(255));
  endtask

  // drop valid and hold off until every word sent so far has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  initial begin
    int   start;
    int   scene;
    int   pick;
    logic lb;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset values, every register, loopback, DLAB, break
    send_word(OP_READ,  REG_IIR, 8'h00);
    send_word(OP_READ,  REG_LSR, 8'h00);
    send_word(OP_READ,  REG_THR, 8'h00);    // empty FIFO reads zero
    send_word(OP_WRITE, REG_SCR, 8'hff);
    send_word(OP_READ,  REG_SCR, 8'h00);
    send_word(OP_WRITE, REG_SCR, 8'h00);
    send_word(OP_WRITE, REG_IER, 8'h0f);
    send_word(OP_WRITE, REG_THR, 8'ha5);
    send_word(OP_WRITE, REG_LSR, 8'hff);    // read-only, ignored
    send_word(OP_WRITE, REG_MSR, 8'hff);
    send_word(OP_RX,    REG_SCR, 8'h00);
    send_word(OP_RX,    REG_THR, 8'hff);
    send_word(OP_WRITE, REG_MCR, 8'h1f);
    send_word(OP_RX,    REG_THR, 8'h33);    // dropped in loopback
    send_word(OP_WRITE, REG_THR, 8'h5a);    // loops into the FIFO
    send_word(OP_READ,  REG_MSR, 8'h00);
    send_word(OP_WRITE, REG_MCR, 8'h00);
    send_word(OP_WRITE, REG_LCR, 8'h80);
    send_word(OP_WRITE, REG_THR, 8'hff);
    send_word(OP_WRITE, REG_IER, 8'hff);
    send_word(OP_READ,  REG_THR, 8'h00);
    send_word(OP_READ,  REG_IER, 8'h00);
    send_word(OP_WRITE, REG_LCR, 8'h43);
    send_word(OP_READ,  REG_LSR, 8'h00);
    send_word(OP_TICK,  REG_SCR, 8'hff);
    send_word(OP_WRITE, REG_IIR, 8'hc7);
    wait_drained();

    start = n_sent;
    scene = 0;
    while (n_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (scene % 25 == 1) pick = 100;
      if (pick < 40) begin
        repeat ($urandom_range(30, 10)) send_random_item();
      end else if (pick < 55) begin
        // fill past the top of the FIFO to hit overrun
        send_word(OP_WRITE, REG_MCR, rand_byte(15));
        repeat ($urandom_range(20, 12)) send_word(OP_RX, rand_off(), rand_byte(255));
        send_word(OP_READ, REG_IIR, rand_byte(255));
        send_word(OP_READ, REG_LSR, rand_byte(255));
      end else if (pick < 70) begin
        send_word(OP_WRITE, REG_LCR, write_value(REG_LCR) & 8'h3f);
        send_word(OP_READ, REG_LSR, rand_byte(255));
        repeat ($urandom_range(18, 4)) send_word(OP_READ, REG_THR, rand_byte(255));
        send_word(OP_READ, REG_IIR, rand_byte(255));
        send_word(OP_READ, REG_MSR, rand_byte(255));
      end else if (pick < 90) begin
        send_word(OP_WRITE, REG_LCR, 8'h80);
        send_word(OP_WRITE, REG_THR, $urandom_range(1) ? rand_byte(3) : rand_byte(255));
        send_word(OP_WRITE, REG_IER, ($urandom_range(3) != 0) ? 8'h00 : rand_byte(255));
        send_word(OP_WRITE, REG_LCR, write_value(REG_LCR));
        send_word(OP_WRITE, REG_IIR, write_value(REG_IIR));
        send_word(OP_WRITE, REG_IER, rand_byte(255));
        send_word(OP_WRITE, REG_MCR, write_value(REG_MCR));
        send_word(OP_WRITE, REG_SCR, rand_byte(255));
      end else if (pick < 100) begin
        wait_drained();
      end else begin
        // character timeout: shortest divisor, a few bytes, then run the clock out
        lb = 1'($urandom_range(1));
        send_word(OP_WRITE, REG_LCR, 8'h80);
        send_word(OP_WRITE, REG_THR, rand_byte(1));
        send_word(OP_WRITE, REG_IER, 8'h00);
        send_word(OP_WRITE, REG_LCR, rand_byte(63));
        send_word(OP_WRITE, REG_IIR, 8'h03 | (rand_byte(3) << 6) | (rand_byte(1) << 2));
        send_word(OP_WRITE, REG_IER, rand_byte(15));
        send_word(OP_WRITE, REG_MCR, lb ? (8'h10 | rand_byte(15)) : rand_byte(15));
        repeat ($urandom_range(3, 1)) begin
          if (lb)
            send_word(OP_WRITE, REG_THR, rand_byte(255));
          else
            send_word(OP_RX, rand_off(), rand_byte(255));
        end
        repeat (TMO_TICKS + $urandom_range(8)) send_word(OP_TICK, rand_off(), rand_byte(255));
        send_word(OP_READ, REG_IIR, rand_byte(255));
        send_word(OP_READ, REG_LSR, rand_byte(255));
        send_word(OP_READ, REG_THR, rand_byte(255));
        send_word(OP_READ, REG_IIR, rand_byte(255));
      end
      scene++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("PASS uart_16550_register_block_core");
    else
      $display("FAIL uart_16550_register_block_core");
    $finish;
  end

endmodule
